### rtl/sacs_pkg.sv
// Package for the serial converter command slave.
// Holds shared widths, command field constants and the step struct.
// No dependencies.
package sacs_pkg;

   localparam int NUM_CHANNELS      = 8;
   localparam int CHAN_BITS         = 3;
   localparam int VALUE_BITS        = 12;
   localparam int WORD_BITS         = 16;
   localparam int COUNT_BITS        = 5;
   localparam int INDEX_BITS        = 4;
   localparam int COMMAND_BITS      = 8;
   localparam int CMD_COUNT_BITS    = 3;
   localparam int MAX_EXCHANGE_BITS = 16;
   localparam int CHANNEL_LSB       = 4;
   localparam int VALUE_SHIFT       = 4;

   typedef logic [NUM_CHANNELS-1:0][VALUE_BITS-1:0] chan_array_type;

   typedef struct packed {
      logic valid;
      logic bit_in;
   } step_type;

endpackage

### rtl/sacs_bit_engine.sv
// Per-bit engine: output shift register, start-bit hunt, command gather
// and pending value. Depends on sacs_pkg.
module sacs_bit_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  sacs_pkg::step_type      step,
   input  sacs_pkg::chan_array_type chan_values,
   output logic                    bit_out
);
   import sacs_pkg::*;

   logic [COMMAND_BITS-1:0]   cmd_ff,      cmd_in;
   logic [CMD_COUNT_BITS-1:0] cmd_cnt_ff,  cmd_cnt_in;
   logic [WORD_BITS-1:0]      out_ff,      out_in;
   logic [WORD_BITS-1:0]      pend_val_ff, pend_val_in;
   logic                      pend_ff,     pend_in;
   logic [CHAN_BITS-1:0]      chan_sel;

   assign bit_out  = out_ff[WORD_BITS-1];
   assign chan_sel = cmd_in[CHANNEL_LSB +: CHAN_BITS];

   always_comb begin
      cmd_in      = cmd_ff;
      cmd_cnt_in  = cmd_cnt_ff;
      out_in      = out_ff;
      pend_val_in = pend_val_ff;
      pend_in     = pend_ff;
      if (step.valid) begin
         out_in = {out_ff[WORD_BITS-2:0], 1'b0};
         if (cmd_cnt_ff == '0) begin
            if (step.bit_in) begin
               cmd_in     = COMMAND_BITS'(1);
               cmd_cnt_in = CMD_COUNT_BITS'(1);
            end
            if (pend_ff) begin
               pend_in = 1'b0;
               out_in  = pend_val_ff;
            end
         end else begin
            cmd_in = {cmd_ff[COMMAND_BITS-2:0], step.bit_in};
            if (cmd_cnt_ff == CMD_COUNT_BITS'(COMMAND_BITS - 1)) begin
               cmd_cnt_in  = '0;
               pend_in     = 1'b1;
               pend_val_in = {chan_values[chan_sel], {VALUE_SHIFT{1'b0}}};
            end else begin
               cmd_cnt_in = cmd_cnt_ff + CMD_COUNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff      <= '0;
         cmd_cnt_ff  <= '0;
         out_ff      <= '0;
         pend_val_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         cmd_ff      <= cmd_in;
         cmd_cnt_ff  <= cmd_cnt_in;
         out_ff      <= out_in;
         pend_val_ff <= pend_val_in;
         pend_ff     <= pend_in;
      end
   end

endmodule

### rtl/spi_adc_command_slave.sv
// Serial command slave of an eight-channel converter. Each request carries
// 1 to 16 bits (counts above 16 act as 16, a zero count returns zero and
// changes nothing); they are handled one bit per cycle, most significant
// first, by a bit-serial engine. After the last bit the response waits
// until the output register can take it, and the next request is taken in the
// cycle the response is handed to the output register. Commands open with
// a start bit, span requests freely, and pick one of eight channel values
// written through the csr port; that value, shifted left by four, is
// shifted out starting one bit after the next start-bit hunt bit.
// Depends on sacs_pkg and sacs_bit_engine.
module spi_adc_command_slave (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sacs_pkg::COUNT_BITS-1:0]     req_bit_count,
   input  logic [sacs_pkg::WORD_BITS-1:0]      req_tx_bits,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sacs_pkg::WORD_BITS-1:0]      rsp_rx_bits,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sacs_pkg::INDEX_BITS-1:0]     csr_index,
   input  logic [sacs_pkg::VALUE_BITS-1:0]     csr_wdata
);
   import sacs_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_SHIFT = 1'b1;

   logic                   state_ff,  state_in;
   logic [COUNT_BITS-1:0]  cnt_ff,    cnt_in;
   logic [WORD_BITS-1:0]   tx_ff,     tx_in;
   logic [WORD_BITS-1:0]   rx_ff,     rx_in;
   logic [WORD_BITS-1:0]   rsp_rx_ff, rsp_rx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   chan_array_type         chan_ff;
   logic [COUNT_BITS-1:0]  bit_idx;
   logic [COUNT_BITS-1:0]  clamped;
   logic                   accept;
   logic                   finish;
   logic                   bit_out;
   step_type               step;

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_rx_bits = rsp_rx_ff;

   assign finish    = (state_ff == ST_SHIFT) && (cnt_ff == '0) &&
                      (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff == ST_SHIFT) && !finish;
   assign accept    = req_valid && !req_stall;

   assign clamped = (req_bit_count > COUNT_BITS'(MAX_EXCHANGE_BITS)) ?
                    COUNT_BITS'(MAX_EXCHANGE_BITS) : req_bit_count;
   assign bit_idx = cnt_ff - COUNT_BITS'(1);

   assign step.valid  = (state_ff == ST_SHIFT) && (cnt_ff != '0);
   assign step.bit_in = tx_ff[bit_idx[3:0]];

   sacs_bit_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .chan_values (chan_ff),
      .bit_out     (bit_out)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tx_in        = tx_ff;
      rx_in        = rx_ff;
      rsp_rx_in    = rsp_rx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (step.valid) begin
         rx_in  = {rx_ff[WORD_BITS-2:0], bit_out};
         cnt_in = bit_idx;
      end
      if (finish) begin
         rsp_rx_in    = rx_ff;
         rsp_valid_in = 1'b1;
         state_in     = ST_IDLE;
      end
      if (accept) begin
         state_in = ST_SHIFT;
         cnt_in   = clamped;
         tx_in    = req_tx_bits;
         rx_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff     <= tx_in;
      rx_ff     <= rx_in;
      rsp_rx_ff <= rsp_rx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0;
      end else if (csr_valid && csr_ready &&
                   (csr_index < INDEX_BITS'(NUM_CHANNELS))) begin
         chan_ff[csr_index[CHAN_BITS-1:0]] <= csr_wdata;
      end
   end

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SHIFT))
      else $error("accepted request did not start shifting");

   a_no_early_end : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) && (cnt_ff != '0) |=> (state_ff == ST_SHIFT))
      else $error("shifting ended with bits left");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (cnt_ff <= COUNT_BITS'(MAX_EXCHANGE_BITS)))
      else $error("bit count beyond exchange limit");

   a_finish_loads : assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished request not presented");

endmodule
